/* design/urs_pkg.sv */
// shared types, constants and the half-step table of the radar sweep controller
package urs_pkg;

  typedef enum logic [4:0] {
    PH_TRIGGER = 5'b00001,
    PH_WAIT    = 5'b00010,
    PH_COUNT   = 5'b00100,
    PH_STEP    = 5'b01000,
    PH_SETTLE  = 5'b10000
  } phase_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_HALF_STEPS        = 3'd0;
  localparam logic [2:0] REG_STEP_PERIOD_TICKS = 3'd1;
  localparam logic [2:0] REG_TRIGGER_TICKS     = 3'd2;
  localparam logic [2:0] REG_ECHO_TIMEOUT      = 3'd3;
  localparam logic [2:0] REG_SWEEP_MAX         = 3'd4;

  localparam logic [7:0]  RST_HALF_STEPS        = 8'd11;
  localparam logic [15:0] RST_STEP_PERIOD_TICKS = 16'd500;
  localparam logic [7:0]  RST_TRIGGER_TICKS     = 8'd10;
  localparam logic [14:0] RST_ECHO_TIMEOUT      = 15'd30000;
  localparam logic [7:0]  RST_SWEEP_MAX         = 8'd180;

  localparam logic [14:0] COUNT_CAP = 15'h7FFF;
  localparam logic [15:0] TIMER_CAP = 16'hFFFF;

  // count / 58 as (count * ceil(2^21 / 58)) >> 21, exact for 15-bit counts
  localparam logic [15:0] CM_RECIP = 16'd36158;
  localparam int          CM_SHIFT = 21;

  typedef struct packed {
    logic [9:0] report_distance;
    logic [7:0] report_angle;
    logic       report_valid;
    logic [3:0] coil_drive;
    logic       trigger_out;
  } result_t;

  function automatic logic [3:0] coil_seq(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

/* design/ultrasonic_radar_sweep_controller_core.sv */
// top level of the ultrasonic radar sweep controller: ranging, stepper drive, sweep
//
//  channel  | dir | payload (low bit first)
//  ---------+-----+--------------------------------------------------------------
//  s_t*     | in  | echo_level[0]
//  m_t*     | out | trigger_out[0] coil_drive[4:1] report_valid[5]
//           |     | report_angle[13:6] report_distance[23:14]
//  apb      | in  | five registers at byte address 4*index
//
//  every request gives one result in the next cycle; a request is taken every cycle
//  that m_t* does not stall; the state update and the divide by 58 sit between the
//  state registers and the result register, so the rate is one request per clock
//  s_tready is low during reset and while a held result is not taken on m_t*
//  rst (synchronous) restores register defaults and the trigger phase
module ultrasonic_radar_sweep_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // echo_level[0], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // trigger_out, coil_drive, report_valid,
                                 // report_angle, report_distance
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  half_steps;
  logic [15:0] step_period_ticks;
  logic [7:0]  trigger_ticks;
  logic [14:0] echo_timeout;
  logic [7:0]  sweep_max;

  urs_pkg::phase_t phase, phase_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [14:0] echo_count, echo_count_next;
  logic [2:0]  step_index, step_index_next;
  logic [3:0]  coil_pattern, coil_pattern_next;
  logic [7:0]  sweep_angle, sweep_angle_next;
  logic        sweep_down, sweep_down_next;
  logic [7:0]  steps_remaining, steps_remaining_next;

  logic            accept;
  logic            cfg_write;
  logic [2:0]      cfg_index;
  logic            echo;
  logic            done;
  logic [14:0]     count_inc;
  logic [15:0]     timer_inc;
  logic [7:0]      angle_adv;
  logic            down_adv;
  logic [2:0]      idx_step;
  logic [9:0]      distance;
  urs_pkg::result_t result_next;
  urs_pkg::result_t result;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      half_steps        <= urs_pkg::RST_HALF_STEPS;
      step_period_ticks <= urs_pkg::RST_STEP_PERIOD_TICKS;
      trigger_ticks     <= urs_pkg::RST_TRIGGER_TICKS;
      echo_timeout      <= urs_pkg::RST_ECHO_TIMEOUT;
      sweep_max         <= urs_pkg::RST_SWEEP_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        urs_pkg::REG_HALF_STEPS:        half_steps        <= pwdata[7:0];
        urs_pkg::REG_STEP_PERIOD_TICKS: step_period_ticks <= pwdata[15:0];
        urs_pkg::REG_TRIGGER_TICKS:     trigger_ticks     <= pwdata[7:0];
        urs_pkg::REG_ECHO_TIMEOUT:      echo_timeout      <= pwdata[14:0];
        urs_pkg::REG_SWEEP_MAX:         sweep_max         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      urs_pkg::REG_HALF_STEPS:        prdata = {24'd0, half_steps};
      urs_pkg::REG_STEP_PERIOD_TICKS: prdata = {16'd0, step_period_ticks};
      urs_pkg::REG_TRIGGER_TICKS:     prdata = {24'd0, trigger_ticks};
      urs_pkg::REG_ECHO_TIMEOUT:      prdata = {17'd0, echo_timeout};
      urs_pkg::REG_SWEEP_MAX:         prdata = {24'd0, sweep_max};
      default:                        prdata = 32'd0;
    endcase
  end

  // result register frees up whenever its content is taken
  assign s_tready = ~rst & (~m_tvalid | m_tready);
  assign accept   = s_tvalid & s_tready;
  assign echo     = s_tdata[0];

  assign count_inc = (echo_count != urs_pkg::COUNT_CAP) ? echo_count + 15'd1 : echo_count;
  assign timer_inc = (phase_timer != urs_pkg::TIMER_CAP) ? phase_timer + 16'd1 : phase_timer;
  assign idx_step  = sweep_down ? step_index - 3'd1 : step_index + 3'd1;

  // angle saturates at both ends; direction follows the new angle
  always_comb begin
    if (sweep_down) begin
      angle_adv = (sweep_angle != 8'd0) ? sweep_angle - 8'd1 : sweep_angle;
    end else begin
      angle_adv = (sweep_angle != 8'hFF) ? sweep_angle + 8'd1 : sweep_angle;
    end
    if (angle_adv >= sweep_max) begin
      down_adv = 1'b1;
    end else if (angle_adv == 8'd0) begin
      down_adv = 1'b0;
    end else begin
      down_adv = sweep_down;
    end
  end

  always_comb begin
    phase_next           = phase;
    phase_timer_next     = phase_timer;
    echo_count_next      = echo_count;
    step_index_next      = step_index;
    coil_pattern_next    = coil_pattern;
    sweep_angle_next     = sweep_angle;
    sweep_down_next      = sweep_down;
    steps_remaining_next = steps_remaining;
    done                 = 1'b0;
    case (phase)
      urs_pkg::PH_TRIGGER: begin
        phase_timer_next = timer_inc;
        if (timer_inc >= {8'd0, trigger_ticks}) begin
          phase_next       = urs_pkg::PH_WAIT;
          phase_timer_next = 16'd0;
        end
      end
      urs_pkg::PH_WAIT: begin
        if (echo) begin
          phase_next      = urs_pkg::PH_COUNT;
          echo_count_next = 15'd0;
        end
      end
      urs_pkg::PH_COUNT: begin
        if (echo) begin
          echo_count_next = count_inc;
          done = (count_inc > echo_timeout) || (count_inc == urs_pkg::COUNT_CAP);
        end else begin
          done = 1'b1;
        end
        if (done) begin
          steps_remaining_next = half_steps;
          phase_timer_next     = 16'd0;
          if (half_steps == 8'd0) begin
            sweep_angle_next = angle_adv;
            sweep_down_next  = down_adv;
            phase_next       = urs_pkg::PH_TRIGGER;
          end else begin
            phase_next = urs_pkg::PH_STEP;
          end
        end
      end
      urs_pkg::PH_STEP: begin
        step_index_next   = idx_step;
        coil_pattern_next = urs_pkg::coil_seq(idx_step);
        if (steps_remaining != 8'd0) begin
          steps_remaining_next = steps_remaining - 8'd1;
        end
        phase_timer_next = 16'd0;
        phase_next       = urs_pkg::PH_SETTLE;
      end
      urs_pkg::PH_SETTLE: begin
        phase_timer_next = timer_inc;
        if (timer_inc >= step_period_ticks) begin
          phase_timer_next = 16'd0;
          if (steps_remaining == 8'd0) begin
            sweep_angle_next = angle_adv;
            sweep_down_next  = down_adv;
            phase_next       = urs_pkg::PH_TRIGGER;
          end else begin
            phase_next = urs_pkg::PH_STEP;
          end
        end
      end
      default: begin
        phase_next       = urs_pkg::PH_TRIGGER;
        phase_timer_next = 16'd0;
      end
    endcase
  end

  urs_div58 u_div58 (
    .count    (echo_count_next),
    .distance (distance)
  );

  always_comb begin
    result_next.trigger_out     = (phase == urs_pkg::PH_TRIGGER);
    result_next.coil_drive      = coil_pattern_next;
    result_next.report_valid    = done;
    result_next.report_angle    = done ? sweep_angle : 8'd0;
    result_next.report_distance = done ? distance : 10'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= urs_pkg::PH_TRIGGER;
      phase_timer     <= 16'd0;
      echo_count      <= 15'd0;
      step_index      <= 3'd0;
      coil_pattern    <= 4'd0;
      sweep_angle     <= 8'd0;
      sweep_down      <= 1'b0;
      steps_remaining <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      phase_timer     <= phase_timer_next;
      echo_count      <= echo_count_next;
      step_index      <= step_index_next;
      coil_pattern    <= coil_pattern_next;
      sweep_angle     <= sweep_angle_next;
      sweep_down      <= sweep_down_next;
      steps_remaining <= steps_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = result;

endmodule

/* design/urs_div58.sv */
// echo count to centimetres: division by 58 through a reciprocal multiply
module urs_div58 (
  input  logic [14:0] count,
  output logic [9:0]  distance
);

  logic [30:0] product;

  assign product  = {16'd0, count} * {15'd0, urs_pkg::CM_RECIP};
  assign distance = product[urs_pkg::CM_SHIFT +: 10];

endmodule

/* design/urs_checker.sv */
// port-level checks for the radar sweep controller, bound to the top level
module urs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // every request yields a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("request accepted but no result followed");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  // a report never coincides with the trigger pulse
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[5] && m_tdata[0]))
    else $error("report during trigger phase");

  // angle and distance are zero outside a report
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[5] |-> m_tdata[23:6] == 18'd0)
    else $error("report fields set without report_valid");

  // saturated count bounds the distance and the coils show a half-step pattern
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:14] <= 10'd564) && ($countones(m_tdata[4:1]) <= 2))
    else $error("distance or coil pattern out of range");

endmodule

bind ultrasonic_radar_sweep_controller_core urs_checker u_urs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
